// ===== rtl/tpd_pkg.sv =====
// Package for the tree path distance block: sizes, memory record types and
// the controller state encoding. Used by tree_path_distance; no dependencies.
`default_nettype none

package tpd_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned EdgeCap  = 2 * (MaxNodes - 1);
  localparam int unsigned EdgeW    = $clog2(EdgeCap);
  localparam int unsigned WeightW  = 16;
  localparam int unsigned DistW    = 26;
  localparam int unsigned DepthW   = NodeW;

  localparam logic [NodeW-1:0] RootNode = NodeW'(1);
  localparam logic [EdgeW-1:0] EdgeLimit = EdgeW'(EdgeCap - 2);

  typedef enum logic [0:0] {
    KIND_EDGE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    logic             valid;
    logic [EdgeW-1:0] slot;
  } head_rec_t;

  typedef struct packed {
    logic [NodeW-1:0]   peer;
    logic [WeightW-1:0] len;
    logic               link_v;
    logic [EdgeW-1:0]   link;
  } edge_rec_t;

  typedef struct packed {
    logic              reached;
    logic [NodeW-1:0]  parent;
    logic [DepthW-1:0] depth;
    logic [DistW-1:0]  root_len;
  } node_rec_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_EA_RD,
    S_EA_WR,
    S_EB_RD,
    S_EB_WR,
    S_B_CLR,
    S_B_ROOT,
    S_B_POP,
    S_B_X,
    S_B_H,
    S_B_E,
    S_B_C,
    S_Q_A,
    S_Q_B,
    S_Q_CHK,
    S_LIFT,
    S_LU,
    S_LV,
    S_RES
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/tree_path_distance.sv =====
// An edge transfer runs through the states EA_RD, EA_WR, EB_RD and EB_WR. A query reads
// both nodes, then lifts one level at a time (both nodes climb once their depths match),
// every read going through the single node memory port. A query after new edges first
// rebuilds the tree: node records are cleared, then the nodes and their stored edge
// records are visited breadth-first. One item is in work at a time. After reset the
// adjacency heads are cleared; no item is taken then. Depends on tpd_pkg.
`default_nettype none

module tree_path_distance (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [tpd_pkg::NodeW-1:0]    node_a_i,
  input  wire logic [tpd_pkg::NodeW-1:0]    node_b_i,
  input  wire logic [tpd_pkg::WeightW-1:0]  weight_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tpd_pkg::DistW-1:0]         distance_o,
  output logic [tpd_pkg::NodeW-1:0]         common_ancestor_o,
  output logic                              status_o
);

  localparam int unsigned NodeW   = tpd_pkg::NodeW;
  localparam int unsigned EdgeW   = tpd_pkg::EdgeW;
  localparam int unsigned WeightW = tpd_pkg::WeightW;
  localparam int unsigned DistW   = tpd_pkg::DistW;
  localparam int unsigned DepthW  = tpd_pkg::DepthW;

  tpd_pkg::state_e state_q, state_d;

  // Memories
  tpd_pkg::head_rec_t head_mem [tpd_pkg::MaxNodes];
  tpd_pkg::edge_rec_t edge_mem [tpd_pkg::EdgeCap];
  tpd_pkg::node_rec_t node_mem [tpd_pkg::MaxNodes];
  logic [NodeW-1:0]   queue_mem [tpd_pkg::MaxNodes];

  tpd_pkg::head_rec_t head_rdata, head_wdata;
  tpd_pkg::edge_rec_t edge_rdata, edge_wdata;
  tpd_pkg::node_rec_t node_rdata, node_wdata;
  logic [NodeW-1:0]   queue_rdata;

  logic [NodeW-1:0] head_raddr, head_waddr, node_raddr, node_waddr;
  logic [EdgeW-1:0] edge_raddr, edge_waddr;
  logic [NodeW-1:0] queue_raddr, queue_waddr, queue_wdata;
  logic             head_we, edge_we, node_we, queue_we;

  // Control and datapath registers
  logic [NodeW-1:0]   cnt_q;
  logic [EdgeW-1:0]   edge_total_q;
  logic               tree_ready_q;
  logic [NodeW-1:0]   a_q, b_q;
  logic [WeightW-1:0] w_q;
  logic [NodeW:0]     rd_q, wr_q;
  logic [NodeW-1:0]   x_q;
  logic [DepthW-1:0]  xdepth_q;
  logic [DistW-1:0]   xdist_q;
  tpd_pkg::edge_rec_t e_q;
  tpd_pkg::node_rec_t na_q;
  logic [NodeW-1:0]   u_q, v_q, pu_q, pv_q;
  logic [DepthW-1:0]  du_q, dv_q;
  logic [DistW-1:0]   distu_q;
  logic [DistW:0]     distsum_q;
  logic               both_q;
  logic [DistW-1:0]   res_dist_q;
  logic [NodeW-1:0]   res_anc_q;
  logic               res_stat_q;
  logic               out_valid_q;
  logic [DistW-1:0]   out_dist_q;
  logic [NodeW-1:0]   out_anc_q;
  logic               out_stat_q;

  logic in_fire, edge_ok, query_bad, new_node;
  logic [DistW:0] dist_full;

  assign in_ready_o = (state_q == tpd_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign edge_ok    = (node_a_i != '0) && (node_b_i != '0) &&
                      (edge_total_q <= tpd_pkg::EdgeLimit);
  assign query_bad  = (a_q == '0) || (b_q == '0) || !na_q.reached || !node_rdata.reached;
  assign new_node   = !node_rdata.reached && !wr_q[NodeW];
  assign dist_full  = distsum_q - {distu_q, 1'b0};

  // Memory ports: one write and one registered read per memory and cycle
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    queue_rdata <= queue_mem[queue_raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpd_pkg::S_INIT:   if (cnt_q == '1) state_d = tpd_pkg::S_IDLE;
      tpd_pkg::S_IDLE: begin
        if (in_fire) begin
          if (kind_i == tpd_pkg::KIND_QUERY) begin
            state_d = tree_ready_q ? tpd_pkg::S_Q_A : tpd_pkg::S_B_CLR;
          end else if (edge_ok) begin
            state_d = tpd_pkg::S_EA_RD;
          end
        end
      end
      tpd_pkg::S_EA_RD:  state_d = tpd_pkg::S_EA_WR;
      tpd_pkg::S_EA_WR:  state_d = tpd_pkg::S_EB_RD;
      tpd_pkg::S_EB_RD:  state_d = tpd_pkg::S_EB_WR;
      tpd_pkg::S_EB_WR:  state_d = tpd_pkg::S_IDLE;
      tpd_pkg::S_B_CLR:  if (cnt_q == '1) state_d = tpd_pkg::S_B_ROOT;
      tpd_pkg::S_B_ROOT: state_d = tpd_pkg::S_B_POP;
      tpd_pkg::S_B_POP:  state_d = (rd_q == wr_q) ? tpd_pkg::S_Q_A : tpd_pkg::S_B_X;
      tpd_pkg::S_B_X:    state_d = tpd_pkg::S_B_H;
      tpd_pkg::S_B_H:    state_d = head_rdata.valid ? tpd_pkg::S_B_E : tpd_pkg::S_B_POP;
      tpd_pkg::S_B_E:    state_d = tpd_pkg::S_B_C;
      tpd_pkg::S_B_C:    state_d = e_q.link_v ? tpd_pkg::S_B_E : tpd_pkg::S_B_POP;
      tpd_pkg::S_Q_A:    state_d = tpd_pkg::S_Q_B;
      tpd_pkg::S_Q_B:    state_d = tpd_pkg::S_Q_CHK;
      tpd_pkg::S_Q_CHK:  state_d = query_bad ? tpd_pkg::S_RES : tpd_pkg::S_LIFT;
      tpd_pkg::S_LIFT: begin
        if (du_q != dv_q || u_q != v_q) state_d = tpd_pkg::S_LU;
        else                            state_d = tpd_pkg::S_RES;
      end
      tpd_pkg::S_LU:     state_d = both_q ? tpd_pkg::S_LV : tpd_pkg::S_LIFT;
      tpd_pkg::S_LV:     state_d = tpd_pkg::S_LIFT;
      tpd_pkg::S_RES:    if (!out_valid_q || out_ready_i) state_d = tpd_pkg::S_IDLE;
      default:           state_d = tpd_pkg::S_INIT;
    endcase
  end

  // Memory controls
  always_comb begin
    head_raddr  = a_q;
    head_waddr  = a_q;
    head_wdata  = '{valid: 1'b1, slot: edge_total_q};
    head_we     = 1'b0;
    edge_raddr  = e_q.link;
    edge_waddr  = edge_total_q;
    edge_wdata  = '{peer: b_q, len: w_q, link_v: head_rdata.valid, link: head_rdata.slot};
    edge_we     = 1'b0;
    node_raddr  = a_q;
    node_waddr  = cnt_q;
    node_wdata  = '0;
    node_we     = 1'b0;
    queue_raddr = rd_q[NodeW-1:0];
    queue_waddr = wr_q[NodeW-1:0];
    queue_wdata = e_q.peer;
    queue_we    = 1'b0;
    unique case (state_q)
      tpd_pkg::S_INIT: begin
        head_waddr = cnt_q;
        head_wdata = '0;
        head_we    = 1'b1;
      end
      tpd_pkg::S_EA_WR: begin
        edge_we = 1'b1;
        head_we = 1'b1;
      end
      tpd_pkg::S_EB_RD: head_raddr = b_q;
      tpd_pkg::S_EB_WR: begin
        edge_wdata.peer = a_q;
        edge_we    = 1'b1;
        head_waddr = b_q;
        head_we    = 1'b1;
      end
      tpd_pkg::S_B_CLR: node_we = 1'b1;
      tpd_pkg::S_B_ROOT: begin
        node_waddr  = tpd_pkg::RootNode;
        node_wdata  = '{reached: 1'b1, parent: '0, depth: '0, root_len: '0};
        node_we     = 1'b1;
        queue_waddr = '0;
        queue_wdata = tpd_pkg::RootNode;
        queue_we    = 1'b1;
      end
      tpd_pkg::S_B_X: begin
        node_raddr = queue_rdata;
        head_raddr = queue_rdata;
      end
      tpd_pkg::S_B_H: edge_raddr = head_rdata.slot;
      tpd_pkg::S_B_E: node_raddr = edge_rdata.peer;
      tpd_pkg::S_B_C: begin
        node_waddr = e_q.peer;
        node_wdata = '{reached: 1'b1, parent: x_q, depth: xdepth_q + DepthW'(1),
                       root_len: xdist_q + DistW'(e_q.len)};
        node_we    = new_node;
        queue_we   = new_node;
      end
      tpd_pkg::S_Q_A: node_raddr = a_q;
      tpd_pkg::S_Q_B: node_raddr = b_q;
      tpd_pkg::S_LIFT: node_raddr = pu_q;
      tpd_pkg::S_LU: node_raddr = pv_q;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpd_pkg::S_INIT;
      cnt_q        <= '0;
      edge_total_q <= '0;
      tree_ready_q <= 1'b0;
      rd_q         <= '0;
      wr_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tpd_pkg::S_INIT || state_q == tpd_pkg::S_B_CLR) begin
        cnt_q <= cnt_q + NodeW'(1);
      end
      if (state_q == tpd_pkg::S_EA_WR || state_q == tpd_pkg::S_EB_WR) begin
        edge_total_q <= edge_total_q + EdgeW'(1);
      end
      if (state_q == tpd_pkg::S_EB_WR) begin
        tree_ready_q <= 1'b0;
      end
      if (state_q == tpd_pkg::S_B_ROOT) begin
        rd_q <= '0;
        wr_q <= (NodeW+1)'(1);
      end
      if (state_q == tpd_pkg::S_B_POP) begin
        if (rd_q == wr_q) tree_ready_q <= 1'b1;
        else              rd_q <= rd_q + (NodeW+1)'(1);
      end
      if (state_q == tpd_pkg::S_B_C && new_node) begin
        wr_q <= wr_q + (NodeW+1)'(1);
      end
      if (state_q == tpd_pkg::S_RES && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tpd_pkg::S_IDLE: begin
        a_q <= node_a_i;
        b_q <= node_b_i;
        w_q <= weight_i;
      end
      tpd_pkg::S_B_X: x_q <= queue_rdata;
      tpd_pkg::S_B_H: begin
        xdepth_q <= node_rdata.depth;
        xdist_q  <= node_rdata.root_len;
      end
      tpd_pkg::S_B_E: e_q <= edge_rdata;
      tpd_pkg::S_Q_B: na_q <= node_rdata;
      tpd_pkg::S_Q_CHK: begin
        distsum_q <= (DistW+1)'(na_q.root_len) + (DistW+1)'(node_rdata.root_len);
        if (na_q.depth < node_rdata.depth) begin
          u_q <= b_q; du_q <= node_rdata.depth; pu_q <= node_rdata.parent;
          distu_q <= node_rdata.root_len;
          v_q <= a_q; dv_q <= na_q.depth; pv_q <= na_q.parent;
        end else begin
          u_q <= a_q; du_q <= na_q.depth; pu_q <= na_q.parent;
          distu_q <= na_q.root_len;
          v_q <= b_q; dv_q <= node_rdata.depth; pv_q <= node_rdata.parent;
        end
        res_dist_q <= '0;
        res_anc_q  <= '0;
        res_stat_q <= 1'b1;
      end
      tpd_pkg::S_LIFT: begin
        both_q     <= (du_q == dv_q);
        res_dist_q <= dist_full[DistW-1:0];
        res_anc_q  <= u_q;
        res_stat_q <= 1'b0;
      end
      tpd_pkg::S_LU: begin
        u_q     <= pu_q;
        du_q    <= node_rdata.depth;
        pu_q    <= node_rdata.parent;
        distu_q <= node_rdata.root_len;
      end
      tpd_pkg::S_LV: begin
        v_q  <= pv_q;
        dv_q <= node_rdata.depth;
        pv_q <= node_rdata.parent;
      end
      tpd_pkg::S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_dist_q <= res_dist_q;
          out_anc_q  <= res_anc_q;
          out_stat_q <= res_stat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign distance_o        = out_dist_q;
  assign common_ancestor_o = out_anc_q;
  assign status_o          = out_stat_q;

`ifndef SYNTHESIS
  a_bad_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (distance_o == '0 && common_ancestor_o == '0))
    else $error("unreachable query result carries non-zero fields");

  a_edge_total_even : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpd_pkg::S_IDLE) |->
      (edge_total_q[0] == 1'b0 && edge_total_q <= EdgeW'(tpd_pkg::EdgeCap)))
    else $error("edge record count out of range");

  a_lift_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpd_pkg::S_LIFT) |-> (du_q >= dv_q))
    else $error("lifted node shallower than its partner");

  a_busy_no_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpd_pkg::S_B_POP || state_q == tpd_pkg::S_LIFT) |-> !in_ready_o)
    else $error("input ready during a walk");
`endif

endmodule

`default_nettype wire
